@@ rtl/ascd_pkg.sv @@
// ----------------------------------------------------------------------------
// ascd_pkg
// Shared types and constants of the audio section change detector.
// ----------------------------------------------------------------------------
package ascd_pkg;

	localparam int unsigned HISTORY_DEPTH_DEF = 16;

	// -80 dB in Q8.8, ring entries at or below it do not count
	localparam logic signed [15:0] FLOOR_DB = -16'sd20480;

	// APB register map
	localparam int unsigned ADDR_W = 5;
	localparam logic [2:0] REG_INTERVAL = 3'd0;
	localparam logic [2:0] REG_COOLDOWN = 3'd1;
	localparam logic [2:0] REG_JRATIO   = 3'd2;
	localparam logic [2:0] REG_LOW_DB   = 3'd3;
	localparam logic [2:0] REG_HIGH_DB  = 3'd4;

	localparam logic [31:0] INTERVAL_RST = 32'd2000000;
	localparam logic [31:0] COOLDOWN_RST = 32'd8000000;
	localparam logic [15:0] JRATIO_RST   = 16'd77;
	localparam logic [15:0] LOW_DB_RST   = 16'hE200; // -7680
	localparam logic [15:0] HIGH_DB_RST  = 16'hF400; // -3072

	typedef enum logic [2:0] {
		KIND_NONE   = 3'd0,
		KIND_INTRO  = 3'd1,
		KIND_VERSE  = 3'd2,
		KIND_CHORUS = 3'd3,
		KIND_BRIDGE = 3'd4,
		KIND_OUTRO  = 3'd5
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUM,
		ST_DRAIN,
		ST_MUL_CL,
		ST_DIFF,
		ST_MUL_JR,
		ST_DECIDE,
		ST_SM_MUL,
		ST_SM_ADD,
		ST_OUT
	} ascd_state_t;

	typedef enum logic [1:0] {
		SM_LEVEL,
		SM_CENT,
		SM_CORR
	} sm_sel_t;

endpackage

@@ rtl/ascd_if.sv @@
// ----------------------------------------------------------------------------
// ascd_if
// Valid/ready channels of the detector: frame in, result out.
// ----------------------------------------------------------------------------
interface ascd_frame_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] rms_db;
	logic signed [15:0] correlation;
	logic        [15:0] centroid_hz;
	logic        [31:0] song_time_ms;
	logic        [47:0] stamp_us;

	modport source (output valid, rms_db, correlation, centroid_hz, song_time_ms, stamp_us,
		input ready);
	modport sink (input valid, rms_db, correlation, centroid_hz, song_time_ms, stamp_us,
		output ready);
endinterface

interface ascd_result_if;
	logic               valid;
	logic               ready;
	logic               analysed;
	logic               transition;
	logic        [2:0]  section_kind;
	logic        [2:0]  prior_kind;
	logic        [31:0] section_start_ms;
	logic signed [15:0] mean_level_db;
	logic        [15:0] mean_centroid_hz;
	logic signed [15:0] mean_correlation;

	modport source (output valid, analysed, transition, section_kind, prior_kind,
		section_start_ms, mean_level_db, mean_centroid_hz, mean_correlation,
		input ready);
	modport sink (input valid, analysed, transition, section_kind, prior_kind,
		section_start_ms, mean_level_db, mean_centroid_hz, mean_correlation,
		output ready);
endinterface

@@ rtl/ascd_ring.sv @@
// ----------------------------------------------------------------------------
// ascd_ring
// Level history memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ascd_ring import ascd_pkg::*; #(
	parameter int unsigned DEPTH = HISTORY_DEPTH_DEF,
	localparam int unsigned IDX_W = $clog2(DEPTH)
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [IDX_W-1:0]        waddr,
	input  logic signed [15:0]      wdata,
	input  logic [IDX_W-1:0]        raddr,
	output logic signed [15:0]      rdata_q
);

	logic signed [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

endmodule

@@ rtl/ascd_mac.sv @@
// ----------------------------------------------------------------------------
// ascd_mac
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module ascd_mac import ascd_pkg::*; #(
	parameter int unsigned A_W = 21,
	parameter int unsigned B_W = 18
) (
	input  logic                      clk,
	input  logic signed [A_W-1:0]     a,
	input  logic signed [B_W-1:0]     b,
	output logic signed [A_W+B_W-1:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
	end

endmodule

@@ rtl/audio_section_change_detector.sv @@
// ----------------------------------------------------------------------------
// audio_section_change_detector
// Tracks loudness frames, detects section changes by relative level jumps
// and classifies each new section; smooths section means otherwise.
// ----------------------------------------------------------------------------
//
//  port      dir   kind         transfer
//  frame     in    valid/ready  one loudness frame
//  result    out   valid/ready  one result per frame, skid-free output reg
//  psel..    in    APB          config write/read, 5 regs at 4*i
//
//  Flow: one frame at a time. A throttled frame goes straight to the
//  output register. An analysed frame walks the level ring (one read per
//  cycle from the ring memory, up to the fill level), then runs the jump
//  test (MUL_CL, DIFF, MUL_JR, DECIDE) and, without a transition, smooths
//  level, centroid and correlation in turn on the shared multiplier.
//  Reset is asynchronous; ring contents need no clearing since only written
//  slots are ever read. A stalled result holds; the next frame is accepted
//  once the sequencer is back in idle.
// ----------------------------------------------------------------------------
module audio_section_change_detector import ascd_pkg::*; #(
	parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	ascd_frame_if.sink        frame,
	ascd_result_if.source     result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int unsigned IDX_W = $clog2(HISTORY_DEPTH);
	localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam int unsigned SUM_W = IDX_W + 17;   // ring sum, signed
	localparam int unsigned B_W   = 18;
	localparam int unsigned P_W   = SUM_W + B_W;
	localparam int unsigned CMP_W = SUM_W + 9;

	localparam logic signed [CMP_W-1:0] K_FLOOR75 = CMP_W'(19200);
	localparam logic signed [CMP_W-1:0] K_HUNDRED = CMP_W'(100);

	// ---------------- configuration registers ----------------
	logic [31:0] interval_q, cooldown_q;
	logic [15:0] jratio_q;
	logic signed [15:0] low_q, high_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RST;
			cooldown_q <= COOLDOWN_RST;
			jratio_q   <= JRATIO_RST;
			low_q      <= LOW_DB_RST;
			high_q     <= HIGH_DB_RST;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_INTERVAL: interval_q <= pwdata;
				REG_COOLDOWN: cooldown_q <= pwdata;
				REG_JRATIO:   jratio_q   <= pwdata[15:0];
				REG_LOW_DB:   low_q      <= pwdata[15:0];
				REG_HIGH_DB:  high_q     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_INTERVAL: prdata = interval_q;
			REG_COOLDOWN: prdata = cooldown_q;
			REG_JRATIO:   prdata = {16'd0, jratio_q};
			REG_LOW_DB:   prdata = {16'd0, low_q};
			REG_HIGH_DB:  prdata = {16'd0, high_q};
			default:      prdata = 32'd0;
		endcase
	end

	// ---------------- detector state ----------------
	ascd_state_t state_q, state_d;
	sm_sel_t     sm_q;

	logic [IDX_W-1:0] pos_q;
	logic [CNT_W-1:0] fill_q;
	logic [47:0]      last_an_q, last_tr_q;
	kind_t            cur_kind_q, prev_kind_q;
	logic [31:0]      cur_start_q;
	logic signed [15:0] cur_level_q, cur_corr_q;
	logic [15:0]      cur_cen_q;

	// latched frame and working registers
	logic signed [15:0] fr_lvl_q, fr_corr_q;
	logic [15:0]        fr_cen_q;
	logic [31:0]        fr_ms_q;
	logic [47:0]        fr_stamp_q;
	logic               an_q, tr_q;
	logic [IDX_W-1:0]   rd_idx_q;
	logic               rd_vld_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SUM_W:0]     diff_q;
	logic signed [SUM_W-1:0] den_q;
	logic               pre_ok_q;

	// output register
	logic               out_valid_q;
	logic               out_an_q, out_tr_q;
	kind_t              out_kind_q, out_prior_q;
	logic [31:0]        out_start_q;
	logic signed [15:0] out_level_q, out_corr_q;
	logic [15:0]        out_cen_q;

	// ---------------- ring and shared multiplier ----------------
	logic               ring_we;
	logic signed [15:0] ring_rd;
	logic signed [SUM_W-1:0] mac_a;
	logic signed [B_W-1:0]   mac_b;
	logic signed [P_W-1:0]   prod_q;

	ascd_ring #(.DEPTH(HISTORY_DEPTH)) u_ring (
		.clk     (clk),
		.we      (ring_we),
		.waddr   (pos_q),
		.wdata   (frame.rms_db),
		.raddr   (rd_idx_q),
		.rdata_q (ring_rd)
	);

	ascd_mac #(.A_W(SUM_W), .B_W(B_W)) u_mac (
		.clk    (clk),
		.a      (mac_a),
		.b      (mac_b),
		.prod_q (prod_q)
	);

	// ---------------- combinational helpers ----------------
	logic [47:0] since_an, since_tr;
	logic        an_now, cool_ok, jump, trans_now, last_rd, acc_hit, out_free;

	assign since_an = frame.stamp_us - last_an_q;
	assign an_now   = since_an >= 48'(interval_q);
	assign since_tr = fr_stamp_q - last_tr_q;
	assign cool_ok  = since_tr >= 48'(cooldown_q);
	assign jump     = pre_ok_q && ((P_W'(diff_q) << 8) > $unsigned(prod_q));
	assign trans_now = jump && cool_ok;
	assign last_rd  = CNT_W'(rd_idx_q) == (fill_q - CNT_W'(1));
	assign acc_hit  = rd_vld_q && (ring_rd > FLOOR_DB);
	assign out_free = !out_valid_q || result.ready;

	// jump test terms: mean = sum/cnt, all compared by cross multiplication
	logic signed [SUM_W:0]   dv;
	logic signed [CMP_W-1:0] s_x, c_x, abs_s, c256, den_x;
	logic                    floor_ok, small_ok;

	always_comb begin
		dv       = (SUM_W+1)'($signed(prod_q[SUM_W-1:0])) - (SUM_W+1)'(sum_q);
		s_x      = CMP_W'(sum_q);
		c_x      = CMP_W'($signed({1'b0, cnt_q}));
		abs_s    = (s_x < 0) ? -s_x : s_x;
		c256     = c_x <<< 8;
		floor_ok = (s_x + c_x * K_FLOOR75) >= 0;     // mean >= -75 dB
		small_ok = (abs_s * K_HUNDRED) > c256;       // |mean| > 0.01 dB
		den_x    = (abs_s < c256) ? c256 : abs_s;    // max(|mean|, 1 dB) * cnt
	end

	// section classification of the frame that starts a new section
	logic signed [16:0] lvl17, lo17, hi17;
	kind_t              new_kind;

	always_comb begin
		lvl17 = 17'(fr_lvl_q);
		lo17  = 17'(low_q);
		hi17  = 17'(high_q);
		if (fr_ms_q < 32'd10000 && lvl17 < lo17 + 17'sd1280) begin
			new_kind = KIND_INTRO;
		end else if (lvl17 > hi17) begin
			new_kind = KIND_CHORUS;
		end else if (lvl17 < lo17) begin
			new_kind = (fr_ms_q > 32'd90000 && fill_q >= CNT_W'(3)) ? KIND_OUTRO : KIND_BRIDGE;
		end else begin
			new_kind = KIND_VERSE;
		end
	end

	// smoothing: m' = (256*m + 77*(x - m) + 128) >>> 8
	logic signed [17:0] sm_m, sm_x;
	logic signed [27:0] sm_acc;
	logic signed [15:0] sm_new;

	always_comb begin
		case (sm_q)
			SM_LEVEL: begin
				sm_m = 18'(cur_level_q);
				sm_x = 18'(fr_lvl_q);
			end
			SM_CENT: begin
				sm_m = {2'b00, cur_cen_q};
				sm_x = {2'b00, fr_cen_q};
			end
			SM_CORR: begin
				sm_m = 18'(cur_corr_q);
				sm_x = 18'(fr_corr_q);
			end
			default: begin
				sm_m = '0;
				sm_x = '0;
			end
		endcase
		sm_acc = (28'(sm_m) <<< 8) + 28'(prod_q) + 28'sd128;
		sm_new = sm_acc[23:8];
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		frame.ready = 1'b0;
		ring_we     = 1'b0;
		mac_a       = '0;
		mac_b       = '0;
		case (state_q)
			ST_IDLE: begin
				frame.ready = 1'b1;
				if (frame.valid) begin
					ring_we = an_now;
					state_d = an_now ? ST_SUM : ST_OUT;
				end
			end
			ST_SUM: begin
				if (last_rd) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_MUL_CL;
			ST_MUL_CL: begin
				mac_a   = SUM_W'($signed({1'b0, cnt_q}));
				mac_b   = B_W'(fr_lvl_q);
				state_d = ST_DIFF;
			end
			ST_DIFF: state_d = ST_MUL_JR;
			ST_MUL_JR: begin
				mac_a   = den_q;
				mac_b   = $signed({2'b00, jratio_q});
				state_d = ST_DECIDE;
			end
			ST_DECIDE: state_d = trans_now ? ST_OUT : ST_SM_MUL;
			ST_SM_MUL: begin
				mac_a   = SUM_W'(sm_x - sm_m);
				mac_b   = B_W'(77);
				state_d = ST_SM_ADD;
			end
			ST_SM_ADD: state_d = (sm_q == SM_CORR) ? ST_OUT : ST_SM_MUL;
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// architectural state and control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			fill_q      <= '0;
			last_an_q   <= '0;
			last_tr_q   <= '0;
			cur_kind_q  <= KIND_NONE;
			prev_kind_q <= KIND_NONE;
			cur_start_q <= '0;
			cur_level_q <= '0;
			cur_cen_q   <= '0;
			cur_corr_q  <= '0;
			rd_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// load wins over the drain of the previous result
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					rd_vld_q <= 1'b0;
					if (frame.valid && an_now) begin
						last_an_q <= frame.stamp_us;
						pos_q     <= (pos_q == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : pos_q + 1'b1;
						if (fill_q != CNT_W'(HISTORY_DEPTH)) begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				ST_SUM:   rd_vld_q <= 1'b1;
				ST_DRAIN: rd_vld_q <= 1'b0;
				ST_DECIDE: begin
					if (trans_now) begin
						last_tr_q   <= fr_stamp_q;
						prev_kind_q <= cur_kind_q;
						cur_kind_q  <= new_kind;
						cur_start_q <= fr_ms_q;
						cur_level_q <= fr_lvl_q;
						cur_cen_q   <= fr_cen_q;
						cur_corr_q  <= fr_corr_q;
					end
				end
				ST_SM_ADD: begin
					case (sm_q)
						SM_LEVEL: cur_level_q <= sm_new;
						SM_CENT: begin
							if (fr_cen_q != '0) begin
								cur_cen_q <= sm_new;
							end
						end
						SM_CORR:  cur_corr_q <= sm_new;
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				fr_lvl_q   <= frame.rms_db;
				fr_corr_q  <= frame.correlation;
				fr_cen_q   <= frame.centroid_hz;
				fr_ms_q    <= frame.song_time_ms;
				fr_stamp_q <= frame.stamp_us;
				an_q       <= an_now;
				tr_q       <= 1'b0;
				rd_idx_q   <= '0;
				sum_q      <= '0;
				cnt_q      <= '0;
			end
			ST_SUM, ST_DRAIN: begin
				if (state_q == ST_SUM) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				if (acc_hit) begin
					sum_q <= sum_q + SUM_W'(ring_rd);
					cnt_q <= cnt_q + 1'b1;
				end
			end
			ST_DIFF: begin
				diff_q   <= (dv < 0) ? $unsigned(-dv) : $unsigned(dv);
				den_q    <= den_x[SUM_W-1:0];
				pre_ok_q <= (fill_q >= CNT_W'(2)) && (cnt_q != '0) && floor_ok && small_ok;
			end
			ST_DECIDE: begin
				tr_q <= trans_now;
				sm_q <= SM_LEVEL;
			end
			ST_SM_ADD: begin
				case (sm_q)
					SM_LEVEL: sm_q <= SM_CENT;
					SM_CENT:  sm_q <= SM_CORR;
					default:  sm_q <= SM_LEVEL;
				endcase
			end
			ST_OUT: begin
				if (out_free) begin
					out_an_q    <= an_q;
					out_tr_q    <= tr_q;
					out_kind_q  <= cur_kind_q;
					out_prior_q <= prev_kind_q;
					out_start_q <= cur_start_q;
					out_level_q <= cur_level_q;
					out_cen_q   <= cur_cen_q;
					out_corr_q  <= cur_corr_q;
				end
			end
			default: ;
		endcase
	end

	assign result.valid            = out_valid_q;
	assign result.analysed         = out_an_q;
	assign result.transition       = out_tr_q;
	assign result.section_kind     = out_kind_q;
	assign result.prior_kind       = out_prior_q;
	assign result.section_start_ms = out_start_q;
	assign result.mean_level_db    = out_level_q;
	assign result.mean_centroid_hz = out_cen_q;
	assign result.mean_correlation = out_corr_q;

endmodule
